/* rtl/core/teq_pkg.sv */
// Shared types and constants for the timed event queue.
`default_nettype none

package teq_pkg;

  // Command codes carried by an input beat.
  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // Result status codes.
  localparam int unsigned STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE_DUE = 2'd2;

  // Width of the reported occupancy field.
  localparam int unsigned OCC_W = 5;

  // Per-cycle control broadcast to every cell of the row.
  typedef struct packed {
    logic put;
    logic pop;
  } teq_cell_ctl_t;

endpackage : teq_pkg

`default_nettype wire

/* rtl/core/teq_in_if.sv */
// Input channel of the timed event queue: handshake plus command beat.
`default_nettype none

interface teq_in_if #(
  parameter int TIME_WIDTH    = 32,
  parameter int PAYLOAD_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [TIME_WIDTH-1:0]    event_time;
  logic [PAYLOAD_WIDTH-1:0] payload;
  logic [TIME_WIDTH-1:0]    now;

  modport source (output valid, command, event_time, payload, now, input ready);
  modport sink   (input valid, command, event_time, payload, now, output ready);
endinterface : teq_in_if

`default_nettype wire

/* rtl/core/teq_out_if.sv */
// Result channel of the timed event queue: handshake plus result beat.
`default_nettype none

interface teq_out_if #(
  parameter int PAYLOAD_WIDTH = 32
);
  import teq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic                     data_valid;
  logic [PAYLOAD_WIDTH-1:0] payload_out;
  logic                     head_due;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, status, data_valid, payload_out, head_due, occupancy,
                  input ready);
  modport sink   (input valid, status, data_valid, payload_out, head_due, occupancy,
                  output ready);
endinterface : teq_out_if

`default_nettype wire

/* rtl/core/timed_event_queue.sv */
// Top level of the timed event queue: row of sorted cells, fill count and result register.
//
// A bounded queue of events kept sorted by due time. Each input beat is either a
// put (insert event_time/payload behind all entries with time <= event_time) or a
// get (remove the head if its time is not later than now). Every input beat gives
// exactly one result beat with status, the removed payload, whether the head is
// due after the step, and the occupancy.
// Both channels use valid/ready; a beat moves when both are high.
// The whole update happens in the cycle the input beat is accepted: every cell
// compares its time with the new event and shifts, takes the new event, or pulls
// from its right neighbor at once. The result is registered and appears on the
// output register in the cycle after acceptance; throughput is one beat per
// cycle while the receiver takes results.
// When the receiver stalls, the result register holds its beat and in_ch.ready
// drops until the beat is taken; a new beat is accepted in the same cycle the
// pending result leaves.
// Synchronous active-low reset empties the queue and clears the result valid flag;
// cell contents are not cleared, the fill count decides which cells hold events.
`default_nettype none

module timed_event_queue #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int TIME_WIDTH    = 32,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  teq_in_if.sink    in_ch,
  teq_out_if.source out_ch
);
  import teq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic                     data_valid_r, data_valid_nxt;
  logic [PAYLOAD_WIDTH-1:0] payload_out_r, payload_out_nxt;
  logic                     head_due_r, head_due_nxt;
  logic [OCC_W-1:0]         occupancy_r, occupancy_nxt;

  logic [TIME_WIDTH-1:0]    cell_time    [QUEUE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] cell_payload [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   cell_gt;
  logic [QUEUE_DEPTH-1:0]   cell_occ;

  teq_cell_ctl_t ctl;
  logic          accept;
  logic          full;
  logic          put_ok;
  logic          head_due_now;
  logic          second_due;
  logic          new_due;

  // Input handshake: take a beat whenever the result register is free or leaving.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Decode the command against the current fill state.
  assign full         = (count_r == CW'(QUEUE_DEPTH));
  assign head_due_now = (count_r != '0) && (cell_time[0] <= in_ch.now);
  assign second_due   = (count_r > CW'(1)) && (cell_time[1] <= in_ch.now);
  assign new_due      = in_ch.event_time <= in_ch.now;
  assign put_ok       = accept && (in_ch.command == CMD_PUT) && !full;
  assign ctl.put      = put_ok;
  assign ctl.pop      = accept && (in_ch.command == CMD_GET) && head_due_now;

  // Row of cells; cell 0 is the head.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam int LI = (i == 0) ? 0 : i - 1;
    localparam int RI = (i == QUEUE_DEPTH - 1) ? i : i + 1;

    assign cell_occ[i] = count_r > CW'(i);

    teq_cell #(
      .TIME_WIDTH    (TIME_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .occ           (cell_occ[i]),
      .left_gt       ((i == 0) ? 1'b0 : cell_gt[LI]),
      .new_time      (in_ch.event_time),
      .new_payload   (in_ch.payload),
      .left_time     (cell_time[LI]),
      .left_payload  (cell_payload[LI]),
      .right_time    (cell_time[RI]),
      .right_payload (cell_payload[RI]),
      .cell_time     (cell_time[i]),
      .cell_payload  (cell_payload[i]),
      .cell_gt       (cell_gt[i])
    );
  end

  // Fill count follows inserts and removals.
  always_comb begin
    count_nxt = count_r;
    if (ctl.put) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Result beat, built from the state before the update and the new head.
  always_comb begin
    status_nxt      = ST_OK;
    data_valid_nxt  = 1'b0;
    payload_out_nxt = '0;
    head_due_nxt    = head_due_now;
    if (in_ch.command == CMD_PUT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else if (cell_gt[0]) begin
        // The new event becomes the head.
        head_due_nxt = new_due;
      end
    end else begin
      if (head_due_now) begin
        data_valid_nxt  = 1'b1;
        payload_out_nxt = cell_payload[0];
        head_due_nxt    = second_due;
      end else begin
        status_nxt = ST_NONE_DUE;
      end
    end
    occupancy_nxt = OCC_W'(count_nxt);
  end

  // Output register holds a beat until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status_nxt;
      data_valid_r  <= data_valid_nxt;
      payload_out_r <= payload_out_nxt;
      head_due_r    <= head_due_nxt;
      occupancy_r   <= occupancy_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.data_valid  = data_valid_r;
  assign out_ch.payload_out = payload_out_r;
  assign out_ch.head_due    = head_due_r;
  assign out_ch.occupancy   = occupancy_r;

endmodule : timed_event_queue

`default_nettype wire

/* rtl/core/teq_cell.sv */
// One storage cell of the sorted row: holds one event and trades with its neighbors.
`default_nettype none

module teq_cell #(
  parameter int TIME_WIDTH    = 32,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire teq_pkg::teq_cell_ctl_t   ctl,
  input  wire logic                     occ,
  input  wire logic                     left_gt,
  input  wire logic [TIME_WIDTH-1:0]    new_time,
  input  wire logic [PAYLOAD_WIDTH-1:0] new_payload,
  input  wire logic [TIME_WIDTH-1:0]    left_time,
  input  wire logic [PAYLOAD_WIDTH-1:0] left_payload,
  input  wire logic [TIME_WIDTH-1:0]    right_time,
  input  wire logic [PAYLOAD_WIDTH-1:0] right_payload,
  output logic [TIME_WIDTH-1:0]         cell_time,
  output logic [PAYLOAD_WIDTH-1:0]      cell_payload,
  output logic                          cell_gt
);
  import teq_pkg::*;

  logic [TIME_WIDTH-1:0]    time_r, time_nxt;
  logic [PAYLOAD_WIDTH-1:0] payload_r, payload_nxt;

  // An empty cell counts as later than any new event, so the row stays monotonic.
  assign cell_gt = !occ || (time_r > new_time);

  // Keep, shift right on insert, take the new event, or shift left on pop.
  always_comb begin
    time_nxt    = time_r;
    payload_nxt = payload_r;
    if (ctl.put && cell_gt) begin
      if (left_gt) begin
        time_nxt    = left_time;
        payload_nxt = left_payload;
      end else begin
        time_nxt    = new_time;
        payload_nxt = new_payload;
      end
    end else if (ctl.pop) begin
      time_nxt    = right_time;
      payload_nxt = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    time_r    <= time_nxt;
    payload_r <= payload_nxt;
  end

  assign cell_time    = time_r;
  assign cell_payload = payload_r;

endmodule : teq_cell

`default_nettype wire

/* rtl/core/teq_checker.sv */
// Port-level checks for the timed event queue, bound to the top level.
`default_nettype none

module teq_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [teq_pkg::STATUS_W-1:0] out_status,
  input wire logic                         out_data_valid,
  input wire logic                         out_head_due
);
  import teq_pkg::*;

  // A stalled result beat stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // No input beat is taken while a result waits.
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result register is blocked");

  // A removed event always comes with an ok status.
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |-> out_status == ST_OK)
    else $error("removed event reported with an error status");

  // A get that found nothing due leaves no due head and no data.
  a_none_due: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NONE_DUE |-> !out_data_valid && !out_head_due)
    else $error("nothing-due result carries data or a due head");

  // Reset empties the result register.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule : teq_checker

bind timed_event_queue teq_checker u_teq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_data_valid (out_ch.data_valid),
  .out_head_due   (out_ch.head_due)
);

`default_nettype wire
